>>> design/nthm_pkg.sv
`default_nettype none
package nthm_pkg;

    localparam int PLANES   = 16;
    localparam int MAX_HITS = 4096;

    localparam int PLANE_W  = 4;
    localparam int POS_W    = 18;
    localparam int TIME_W   = 48;
    localparam int TOL_W    = 17;
    localparam int CHARGE_W = 16;
    localparam int SIZE_W   = 8;
    localparam int INDEX_W  = 12;
    localparam int DIFF_W   = 24;
    localparam int MASK_W   = 16;

    localparam int CNT_W     = $clog2(MAX_HITS + 1);
    localparam int IN_DATA_W  = 216;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIME_WINDOW    = 4'd0,
        CFG_CHARGE_CUT_LOW = 4'd1,
        CFG_MAX_SIZE       = 4'd2,
        CFG_PLANE_MASK     = 4'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [DIFF_W-1:0]   time_window;
        logic [CHARGE_W-1:0] charge_cut_low;
        logic [SIZE_W-1:0]   max_cluster_size;
        logic [MASK_W-1:0]   plane_mask;
    } cfg_t;

    typedef struct packed {
        logic [PLANE_W-1:0]         plane;
        logic signed [POS_W-1:0]    pred_x;
        logic signed [POS_W-1:0]    pred_y;
        logic signed [TIME_W-1:0]   pred_time;
        logic [TOL_W-1:0]           tolerance;
        logic                       has_cluster;
        logic signed [TIME_W-1:0]   hit_time;
        logic signed [POS_W-1:0]    hit_x;
        logic signed [POS_W-1:0]    hit_y;
        logic [CHARGE_W-1:0]        hit_charge;
        logic [SIZE_W-1:0]          hit_size;
        logic                       last;
    } item_t;

    // per-item verdict, independent of the running minimum
    typedef struct packed {
        logic              eligible;
        logic              dt_fit;
        logic [DIFF_W-1:0] dt;
        logic              last;
    } eval_t;

endpackage
`default_nettype wire

>>> design/nearest_time_hit_match_top.sv
// Nearest-time cluster selection for one query per run of items.
// Slave channel s_*: one cluster item per cycle when ready, each repeating its query;
// s_tuser flags a real cluster (0 = empty-list marker), s_tlast closes the query.
// Master channel m_*: one result per query, m_tuser = found.
// Config channel cfg_*: always ready; write only while no query is in flight.
// Throughput: one item per clock while s_tready stays high. The result of a
// query passes the input register, which takes its last item, then the
// evaluation register, then the running-minimum update into the result register.
// The minimum update is the feedback loop that sets the rate.
// The result register and the pipeline in front of it keep taking items while a
// result waits; only a second last item reaching the update stage while the
// result is still unread stalls the pipeline, and then s_tready drops.
// Reset clears all valid flags and the running state and loads the
// configuration defaults (window 160, charge cut 0, size cut 10, mask 0).
`default_nettype none
module nearest_time_hit_match_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // plane[3:0] pred_x[21:4] pred_y[39:22] pred_time[87:40] tolerance[104:88]
    // hit_time[152:105] hit_x[170:153] hit_y[188:171] hit_charge[204:189]
    // hit_size[212:205], zero padding above
    input  wire logic [nthm_pkg::IN_DATA_W-1:0]  s_tdata,
    // has_cluster[0]
    input  wire logic                            s_tuser,
    input  wire logic                            s_tlast,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // best_index[11:0] best_time_diff[35:12], zero padding above
    output logic [nthm_pkg::OUT_DATA_W-1:0]      m_tdata,
    // found[0]
    output logic                                 m_tuser,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [nthm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [nthm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import nthm_pkg::*;

    cfg_t               cfg_reg;
    logic               in_valid_reg;
    item_t              in_reg;
    item_t              in_item;
    logic               eval_valid;
    eval_t              eval;
    logic               advance;

    logic [DIFF_W-1:0]  best_diff_reg;
    logic [CNT_W-1:0]   best_pos_reg;
    logic               have_best_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [DIFF_W-1:0]  best_diff_next;
    logic [CNT_W-1:0]   best_pos_next;
    logic               have_best_next;
    logic [CNT_W-1:0]   count_next;
    logic [DIFF_W-1:0]  limit;
    logic               in_range;
    logic               take;

    logic               out_valid_reg;
    logic               out_found_reg;
    logic [INDEX_W-1:0] out_index_reg;
    logic [DIFF_W-1:0]  out_diff_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.time_window      <= DIFF_W'(160);
            cfg_reg.charge_cut_low   <= '0;
            cfg_reg.max_cluster_size <= SIZE_W'(10);
            cfg_reg.plane_mask       <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_TIME_WINDOW:    cfg_reg.time_window      <= cfg_data[DIFF_W-1:0];
                CFG_CHARGE_CUT_LOW: cfg_reg.charge_cut_low   <= cfg_data[CHARGE_W-1:0];
                CFG_MAX_SIZE:       cfg_reg.max_cluster_size <= cfg_data[SIZE_W-1:0];
                CFG_PLANE_MASK:     cfg_reg.plane_mask       <= cfg_data[MASK_W-1:0];
                default:            ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // whole pipeline holds only when a finished query cannot enter the result register
    assign advance  = !(eval_valid && eval.last && out_valid_reg && !m_tready);
    assign s_tready = advance;

    always_comb
    begin
        in_item.plane       = s_tdata[3:0];
        in_item.pred_x      = s_tdata[21:4];
        in_item.pred_y      = s_tdata[39:22];
        in_item.pred_time   = s_tdata[87:40];
        in_item.tolerance   = s_tdata[104:88];
        in_item.has_cluster = s_tuser;
        in_item.hit_time    = s_tdata[152:105];
        in_item.hit_x       = s_tdata[170:153];
        in_item.hit_y       = s_tdata[188:171];
        in_item.hit_charge  = s_tdata[204:189];
        in_item.hit_size    = s_tdata[212:205];
        in_item.last        = s_tlast;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s_tvalid)
        begin
            in_reg <= in_item;
        end
    end

    nthm_eval u_eval (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .item_valid (in_valid_reg),
        .item       (in_reg),
        .cfg        (cfg_reg),
        .eval_valid (eval_valid),
        .eval       (eval)
    );

    // running minimum; the first hit is judged against the window itself
    always_comb
    begin
        in_range = (32'(count_reg) < 32'(MAX_HITS));
        limit    = have_best_reg ? best_diff_reg : cfg_reg.time_window;
        take     = eval.eligible && in_range && eval.dt_fit && (eval.dt < limit);

        best_diff_next = take ? eval.dt   : best_diff_reg;
        best_pos_next  = take ? count_reg : best_pos_reg;
        have_best_next = take || have_best_reg;
        count_next     = in_range ? count_reg + CNT_W'(1) : count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_diff_reg <= DIFF_W'(160);
            best_pos_reg  <= '0;
            have_best_reg <= 1'b0;
            count_reg     <= '0;
        end
        else if (advance && eval_valid)
        begin
            if (eval.last)
            begin
                best_diff_reg <= cfg_reg.time_window;
                best_pos_reg  <= '0;
                have_best_reg <= 1'b0;
                count_reg     <= '0;
            end
            else
            begin
                best_diff_reg <= best_diff_next;
                best_pos_reg  <= best_pos_next;
                have_best_reg <= have_best_next;
                count_reg     <= count_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && eval_valid && eval.last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && eval_valid && eval.last)
        begin
            out_found_reg <= have_best_next;
            out_index_reg <= have_best_next ? INDEX_W'(best_pos_next) : '0;
            out_diff_reg  <= have_best_next ? best_diff_next : '0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tdata  = {(OUT_DATA_W - INDEX_W - DIFF_W)'(0), out_diff_reg, out_index_reg};

endmodule
`default_nettype wire

>>> design/nthm_eval.sv
`default_nettype none
module nthm_eval (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           advance,
    input  wire logic           item_valid,
    input  wire nthm_pkg::item_t item,
    input  wire nthm_pkg::cfg_t  cfg,
    output logic                eval_valid,
    output nthm_pkg::eval_t     eval
);
    import nthm_pkg::*;

    logic               eval_valid_reg;
    eval_t              eval_reg;
    eval_t              eval_next;
    logic signed [TIME_W:0] dt_signed;
    logic [TIME_W:0]    dt_abs;
    logic signed [POS_W:0]  dx_signed;
    logic signed [POS_W:0]  dy_signed;
    logic [POS_W:0]     dx_abs;
    logic [POS_W:0]     dy_abs;
    logic               masked;
    logic               spatial_ok;

    always_comb
    begin
        dt_signed = {item.hit_time[TIME_W-1], item.hit_time}
                  - {item.pred_time[TIME_W-1], item.pred_time};
        dt_abs    = dt_signed[TIME_W] ? (TIME_W+1)'(-dt_signed) : dt_signed;
        dx_signed = {item.pred_x[POS_W-1], item.pred_x} - {item.hit_x[POS_W-1], item.hit_x};
        dy_signed = {item.pred_y[POS_W-1], item.pred_y} - {item.hit_y[POS_W-1], item.hit_y};
        dx_abs    = dx_signed[POS_W] ? (POS_W+1)'(-dx_signed) : dx_signed;
        dy_abs    = dy_signed[POS_W] ? (POS_W+1)'(-dy_signed) : dy_signed;
        spatial_ok = (dx_abs <= (POS_W+1)'(item.tolerance))
                  && (dy_abs <= (POS_W+1)'(item.tolerance));
        masked = (32'(item.plane) >= 32'(PLANES)) || cfg.plane_mask[item.plane];

        eval_next.eligible = item.has_cluster && !masked && spatial_ok
                          && (item.hit_charge >= cfg.charge_cut_low)
                          && (item.hit_size <= cfg.max_cluster_size);
        eval_next.dt_fit   = (dt_abs[TIME_W:DIFF_W] == '0);
        eval_next.dt       = dt_abs[DIFF_W-1:0];
        eval_next.last     = item.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eval_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            eval_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            eval_reg <= eval_next;
        end
    end

    assign eval_valid = eval_valid_reg;
    assign eval       = eval_reg;

endmodule
`default_nettype wire

>>> design/nthm_checker.sv
`default_nettype none
module nthm_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic                            s_tlast,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [nthm_pkg::OUT_DATA_W-1:0] m_tdata,
    input  wire logic                            m_tuser
);
    import nthm_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // no match reports zero index and difference
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("empty result carries data");

    // input only backs up behind an unread result
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back-pressure");

    // a fresh result follows an accepted closing item
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast, 3))
        else $error("result without a closing item");

endmodule

bind nearest_time_hit_match_top nthm_checker u_nthm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

>>> verif/nthm_match_checker.sv
`timescale 1ns / 1ps
module nthm_match_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [nthm_pkg::IN_DATA_W-1:0]  s_tdata,
    input  wire logic                            s_tuser,
    input  wire logic                            s_tlast,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [nthm_pkg::OUT_DATA_W-1:0] m_tdata,
    input  wire logic                            m_tuser,
    input  wire logic                            cfg_valid,
    input  wire logic                            cfg_ready,
    input  wire logic [nthm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [nthm_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                                   mismatches,
    output int                                   pending,
    output int                                   items_seen,
    output int                                   results_checked
);
    import nthm_pkg::*;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] index;
        logic [DIFF_W-1:0]  diff;
    } match_t;

    match_t expected_matches[$];

    // shadow of the configuration registers
    logic [DIFF_W-1:0]   window_q;
    logic [CHARGE_W-1:0] charge_min_q;
    logic [SIZE_W-1:0]   size_max_q;
    logic [MASK_W-1:0]   mask_q;

    // running minimum of the query in flight
    logic [DIFF_W-1:0]   run_best_diff;
    logic [INDEX_W-1:0]  run_best_pos;
    logic                run_have_best;
    int                  run_count;

    function automatic longint abs_diff(input longint a, input longint b);
        return (a >= b) ? a - b : b - a;
    endfunction

    task automatic clear_query();
        run_best_diff = window_q;
        run_best_pos  = '0;
        run_have_best = 1'b0;
        run_count     = 0;
    endtask

    task automatic select_nearest(input logic [IN_DATA_W-1:0] d, input logic has,
                                  input logic lst);
        logic [PLANE_W-1:0] plane;
        longint             pred_t;
        longint             hit_t;
        longint             tol;
        longint             dt;
        longint             limit;
        logic               eligible;
        match_t             m;
        plane    = d[3:0];
        pred_t   = longint'($signed(d[87:40]));
        hit_t    = longint'($signed(d[152:105]));
        tol      = longint'(d[104:88]);
        eligible = has && !mask_q[plane] && int'(plane) < PLANES && run_count < MAX_HITS
                   && d[204:189] >= charge_min_q && d[212:205] <= size_max_q;
        if (eligible)
        begin
            dt    = abs_diff(hit_t, pred_t);
            limit = run_have_best ? longint'(run_best_diff) : longint'(window_q);
            if (dt < limit
                && abs_diff(longint'($signed(d[21:4])), longint'($signed(d[170:153]))) <= tol
                && abs_diff(longint'($signed(d[39:22])), longint'($signed(d[188:171]))) <= tol)
            begin
                run_best_diff = DIFF_W'(dt);
                run_best_pos  = INDEX_W'(run_count);
                run_have_best = 1'b1;
            end
        end
        if (run_count < MAX_HITS)
            run_count++;
        if (lst)
        begin
            m.found = run_have_best;
            m.index = run_have_best ? run_best_pos : '0;
            m.diff  = run_have_best ? run_best_diff : '0;
            expected_matches.insert(expected_matches.size(), m);
            clear_query();
        end
    endtask

    task automatic check_result();
        match_t want;
        match_t got;
        got.found = m_tuser;
        got.index = m_tdata[INDEX_W-1:0];
        got.diff  = m_tdata[INDEX_W +: DIFF_W];
        if (expected_matches.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result with none outstanding: found=%0b index=%0d diff=%0d",
                         $time, got.found, got.index, got.diff);
        end
        else
        begin
            want = expected_matches.pop_front();
            results_checked++;
            if (got != want)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: result %0d mismatch: expected found=%0b index=%0d diff=%0d",
                             $time, results_checked, want.found, want.index, want.diff);
                    $display("    got found=%0b index=%0d diff=%0d",
                             got.found, got.index, got.diff);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_q        = 24'd160;
            charge_min_q    = '0;
            size_max_q      = 8'd10;
            mask_q          = '0;
            clear_query();
            expected_matches.delete();
            mismatches      = 0;
            pending         = 0;
            items_seen      = 0;
            results_checked = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TIME_WINDOW:    window_q     = cfg_data[DIFF_W-1:0];
                    CFG_CHARGE_CUT_LOW: charge_min_q = cfg_data[CHARGE_W-1:0];
                    CFG_MAX_SIZE:       size_max_q   = cfg_data[SIZE_W-1:0];
                    CFG_PLANE_MASK:     mask_q       = cfg_data[MASK_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                items_seen++;
                select_nearest(s_tdata, s_tuser, s_tlast);
            end
            if (m_tvalid && m_tready)
                check_result();
            pending = expected_matches.size();
        end
    end

endmodule

>>> verif/nearest_time_hit_match_top_test.sv
`timescale 1ns / 1ps
module nearest_time_hit_match_top_test;
    import nthm_pkg::*;

    localparam int     ITEM_W = $bits(item_t);
    localparam longint T_MAX  = (longint'(1) << 47) - 1;
    localparam longint T_MIN  = -(longint'(1) << 47);
    localparam longint P_MAX  = 131071;
    localparam longint P_MIN  = -131072;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  s_tuser   = 1'b0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int mismatches;
    int pending;
    int items_seen;
    int results_checked;

    // stimulus view of the configuration, used to aim hits at the window and cuts
    logic [DIFF_W-1:0]   cur_window = 24'd160;
    logic [CHARGE_W-1:0] cur_charge = '0;
    logic [SIZE_W-1:0]   cur_size   = 8'd10;
    int                  settings   = 1;
    int                  burst_left = 0;
    int                  stall_mode = 0;
    int                  stall_left = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    nearest_time_hit_match_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    nthm_match_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatches      (mismatches),
        .pending         (pending),
        .items_seen      (items_seen),
        .results_checked (results_checked)
    );

    // result side back-pressure: modes of random length
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 120);
        end
        stall_left--;
        case (stall_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 5) == 0);
            default: m_tready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    function automatic item_t mk(input int plane, input longint px, input longint py,
                                 input longint pt, input longint tol, input bit has,
                                 input longint ht, input longint hx, input longint hy,
                                 input longint charge, input longint size, input bit lst);
        item_t it;
        it.plane       = PLANE_W'(plane);
        it.pred_x      = POS_W'(px);
        it.pred_y      = POS_W'(py);
        it.pred_time   = TIME_W'(pt);
        it.tolerance   = TOL_W'(tol);
        it.has_cluster = has;
        it.hit_time    = TIME_W'(ht);
        it.hit_x       = POS_W'(hx);
        it.hit_y       = POS_W'(hy);
        it.hit_charge  = CHARGE_W'(charge);
        it.hit_size    = SIZE_W'(size);
        it.last        = lst;
        return it;
    endfunction

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(input item_t it);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        burst_left--;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= {3'b000, it.hit_size, it.hit_charge, it.hit_y, it.hit_x, it.hit_time,
                     it.tolerance, it.pred_time, it.pred_y, it.pred_x, it.plane};
        s_tuser  <= it.has_cluster;
        s_tlast  <= it.last;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic put_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic write_config(input logic [DIFF_W-1:0] window,
                                input logic [CHARGE_W-1:0] charge_min,
                                input logic [SIZE_W-1:0] size_max,
                                input logic [MASK_W-1:0] mask);
        put_reg(CFG_TIME_WINDOW, window);
        put_reg(CFG_CHARGE_CUT_LOW, CFG_DATA_W'(charge_min));
        put_reg(CFG_MAX_SIZE, CFG_DATA_W'(size_max));
        put_reg(CFG_PLANE_MASK, CFG_DATA_W'(mask));
        cfg_valid  <= 1'b0;
        cur_window = window;
        cur_charge = charge_min;
        cur_size   = size_max;
        settings++;
    endtask

    // one query: clusters scattered around the window edges and the cuts;
    // zero clusters means a lone empty-list marker
    task automatic send_query(input int clusters);
        item_t  q;
        item_t  it;
        longint span;
        longint off;
        longint prev_off;
        int     tol;
        int     n;
        q.plane     = PLANE_W'($urandom);
        q.pred_x    = POS_W'($urandom_range(0, 240000) - 120000);
        q.pred_y    = POS_W'($urandom_range(0, 240000) - 120000);
        case ($urandom_range(0, 5))
            0:       q.pred_time = TIME_W'({$urandom, $urandom});
            1:       q.pred_time = TIME_W'(T_MAX - $urandom_range(0, 1000));
            2:       q.pred_time = TIME_W'(T_MIN + $urandom_range(0, 1000));
            default: q.pred_time = TIME_W'(longint'(int'($urandom)));
        endcase
        q.tolerance = ($urandom_range(0, 5) == 0) ? TOL_W'($urandom)
                                                  : TOL_W'($urandom_range(0, 3000));
        tol         = int'(q.tolerance);
        span        = longint'(cur_window) + longint'(cur_window) / 4 + 4;
        prev_off    = 0;
        n           = (clusters == 0) ? 1 : clusters;
        for (int i = 0; i < n; i++)
        begin
            it  = q;
            off = ($urandom_range(0, 5) == 0) ? -prev_off
                  : longint'($urandom_range(0, int'(2 * span))) - span;
            prev_off       = off;
            it.hit_time    = q.pred_time + TIME_W'(off);
            it.hit_x       = q.pred_x + POS_W'(int'($urandom_range(0, 2 * tol + 6)) - (tol + 3));
            it.hit_y       = q.pred_y + POS_W'(int'($urandom_range(0, 2 * tol + 6)) - (tol + 3));
            it.hit_charge  = ($urandom_range(0, 1) == 0) ? CHARGE_W'($urandom)
                             : CHARGE_W'(int'(cur_charge) + int'($urandom_range(0, 6)) - 3);
            it.hit_size    = ($urandom_range(0, 1) == 0) ? SIZE_W'($urandom)
                             : SIZE_W'(int'(cur_size) + int'($urandom_range(0, 4)) - 2);
            it.has_cluster = (clusters != 0) && ($urandom_range(0, 9) != 0);
            // noise: a wholly random item, query fields included
            if ($urandom_range(0, 9) == 0)
                it = ITEM_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                              $urandom});
            it.last = (i == n - 1);
            send_item(it);
        end
    endtask

    task automatic random_phase(input int items);
        int sent;
        int n;
        sent = 0;
        while (sent < items)
        begin
            case ($urandom_range(0, 9))
                0:       n = 0;
                1:       n = $urandom_range(20, 60);
                default: n = $urandom_range(1, 10);
            endcase
            send_query(n);
            sent += (n == 0) ? 1 : n;
        end
    endtask

    initial
    begin
        #(5_000_000);
        $display("nearest_time_hit_match_top_test: FAIL");
        $finish;
    end

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // defaults: window 160, no charge cut, size cut 10, nothing masked
        send_item(mk(0, 0, 0, 1000, 100, 0, 1000, 0, 0, 0, 10, 0));   // empty marker mid-list
        send_item(mk(0, 0, 0, 1000, 100, 1, 1159, 0, 0, 0, 10, 0));   // just inside window
        send_item(mk(0, 0, 0, 1000, 100, 1, 840, 0, 0, 0, 10, 0));    // on the window edge
        send_item(mk(0, 0, 0, 1000, 100, 1, 841, 0, 0, 0, 10, 0));    // tie, earlier kept
        send_item(mk(0, 0, 0, 1000, 100, 1, 1000, 0, 0, 0, 11, 0));   // too large
        send_item(mk(0, 0, 0, 1000, 100, 1, 1001, 101, 0, 0, 10, 0)); // just outside in x
        send_item(mk(0, 0, 0, 1000, 100, 1, 995, 100, -100, 0, 10, 1));
        send_item(mk(7, 5, 5, 0, 10, 0, 0, 5, 5, 0, 0, 1));           // empty list
        send_item(mk(15, P_MIN, P_MIN, T_MIN, P_MAX, 1, T_MAX, P_MAX, P_MAX, 65535, 0, 1));
        send_item(mk(15, P_MAX, P_MIN, T_MAX, 0, 1, T_MAX - 3, P_MAX, P_MIN, 65535, 0, 1));

        wait_idle();
        write_config(24'hFFFFFF, 16'd100, 8'd255, 16'h0008);
        send_item(mk(3, 0, 0, 0, 50, 1, 2, 0, 0, 500, 1, 1));         // masked plane
        send_item(mk(4, 0, 0, 0, P_MAX, 1, 0, 0, 0, 99, 255, 0));     // below charge cut
        send_item(mk(4, 0, 0, 0, P_MAX, 1, -16777214, P_MAX, P_MIN, 100, 255, 1));

        wait_idle();
        write_config(24'd0, 16'd0, 8'd255, 16'h0000);
        send_item(mk(1, 0, 0, 77, 5, 1, 77, 0, 0, 0, 0, 1));          // zero window

        for (int ph = 0; ph < 6; ph++)
        begin
            wait_idle();
            case (ph)
                0: write_config(24'hFFFFFF, 16'd0, 8'd255, 16'h0000);
                1: write_config(24'($urandom_range(1, 4000)), 16'($urandom_range(0, 500)),
                                8'($urandom_range(0, 20)), 16'($urandom));
                2: write_config(24'd1, 16'hFFFF, 8'd255, 16'h0000);
                3: write_config(24'($urandom), 16'($urandom), 8'd0, 16'hFFFF);
                4: write_config(24'($urandom), 16'($urandom), 8'($urandom), 16'($urandom));
                default: write_config(24'd160, 16'd0, 8'd10, 16'h0000);
            endcase
            random_phase(139);
        end

        wait_idle();
        $display("%0d items checked as %0d query results under %0d register settings,",
                 items_seen, results_checked, settings);
        $display("including window and cut extremes, masked planes and empty lists");
        if (mismatches == 0 && pending == 0)
            $display("nearest_time_hit_match_top_test: PASS");
        else
            $display("nearest_time_hit_match_top_test: FAIL");
        $finish;
    end

endmodule
